[src/tga_rle_pkg.sv]
`timescale 1ns / 1ps

package tga_rle_pkg;

    localparam int BYTE_W     = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam int DIM_REG_W  = 13;
    localparam int PB_REG_W   = 3;

    localparam int MAX_DIM_DEF = 4096;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PIXEL_BYTES  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RLE_ENABLE   = 2'd3;

    localparam logic [DIM_REG_W-1:0] IMAGE_WIDTH_RST  = 13'd256;
    localparam logic [DIM_REG_W-1:0] IMAGE_HEIGHT_RST = 13'd256;
    localparam logic [PB_REG_W-1:0]  PIXEL_BYTES_RST  = 3'd4;
    localparam logic                 RLE_ENABLE_RST   = 1'b1;

    // Stored pixel formats by byte count.
    localparam logic [PB_REG_W-1:0] PB_GRAY  = 3'd1;
    localparam logic [PB_REG_W-1:0] PB_1555  = 3'd2;
    localparam logic [PB_REG_W-1:0] PB_BGR   = 3'd3;
    localparam logic [PB_REG_W-1:0] PB_BGRA  = 3'd4;

    localparam logic [BYTE_W-1:0] ALPHA_OPAQUE = 8'hFF;
    localparam logic [BYTE_W-1:0] MAX_REPEAT   = 8'd128;

    typedef struct packed {
        logic [BYTE_W-1:0] red;
        logic [BYTE_W-1:0] green;
        logic [BYTE_W-1:0] blue;
        logic [BYTE_W-1:0] alpha;
        logic [BYTE_W-1:0] repeat_res;
        logic              last_of_image;
        logic              overrun;
    } pix_res_t;

endpackage

[src/tga_rle_pixel_decoder.sv]
`timescale 1ns / 1ps
// A byte that completes a pixel has its result word registered into the output stage
// and shown on m_valid; header bytes and partial pixel bytes give no result.
// Throughput: one byte per cycle while s_ready is high; a two-entry output stage
// (register plus skid) keeps taking bytes while one result waits on m_ready.
// Reset (aresetn low, synchronous) restores the default registers; after reset and after
// every configuration write, s_ready stays low while the pixel count loads.
module tga_rle_pixel_decoder #(
    parameter int MAX_DIM = tga_rle_pkg::MAX_DIM_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [tga_rle_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tga_rle_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [tga_rle_pkg::BYTE_W-1:0]      s_data_byte,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [tga_rle_pkg::BYTE_W-1:0]      m_red,
    output logic [tga_rle_pkg::BYTE_W-1:0]      m_green,
    output logic [tga_rle_pkg::BYTE_W-1:0]      m_blue,
    output logic [tga_rle_pkg::BYTE_W-1:0]      m_alpha,
    output logic [tga_rle_pkg::BYTE_W-1:0]      m_repeat_res,
    output logic                                m_last_of_image,
    output logic                                m_overrun
);
    import tga_rle_pkg::*;

    localparam int DIM_MAX_EFF = (MAX_DIM < 8191) ? MAX_DIM : 8191;
    localparam int DW          = $clog2(DIM_MAX_EFF + 1);
    localparam int PIX_W       = $clog2(DIM_MAX_EFF * DIM_MAX_EFF + 1);
    localparam int CNT_W       = (PIX_W > BYTE_W) ? PIX_W : BYTE_W;

    logic [DIM_REG_W-1:0] image_width_reg;
    logic [DIM_REG_W-1:0] image_height_reg;
    logic [PB_REG_W-1:0]  pixel_bytes_reg;
    logic                 rle_enable_reg;
    logic                 reload_reg;

    logic                 expect_header_reg, expect_header_next;
    logic [1:0]           byte_slot_reg, byte_slot_next;
    logic [23:0]          held_bytes_reg, held_bytes_next;
    logic                 run_is_repeat_reg, run_is_repeat_next;
    logic [BYTE_W-1:0]    packet_left_reg, packet_left_next;
    logic [PIX_W-1:0]     pixels_left_reg, pixels_left_next;

    pix_res_t out_reg, out_next, skid_reg, res;
    logic     out_valid_reg, out_valid_next, skid_valid_reg, skid_valid_next;
    logic     res_valid;

    logic [DW-1:0]        width_c, height_c;
    logic [PIX_W-1:0]     image_pixels;
    logic [PB_REG_W-1:0]  pb_eff;
    logic                 fire;

    assign cfg_ready = 1'b1;
    assign s_ready   = !reload_reg && !skid_valid_reg;
    assign fire      = s_valid && s_ready;

    // Register file; every write reloads the image on the following cycle.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_width_reg  <= IMAGE_WIDTH_RST;
            image_height_reg <= IMAGE_HEIGHT_RST;
            pixel_bytes_reg  <= PIXEL_BYTES_RST;
            rle_enable_reg   <= RLE_ENABLE_RST;
            reload_reg       <= 1'b1;
        end else begin
            reload_reg <= cfg_valid;
            if (cfg_valid) begin
                unique case (cfg_index)
                    REG_IMAGE_WIDTH:  image_width_reg  <= cfg_data[DIM_REG_W-1:0];
                    REG_IMAGE_HEIGHT: image_height_reg <= cfg_data[DIM_REG_W-1:0];
                    REG_PIXEL_BYTES:  pixel_bytes_reg  <= cfg_data[PB_REG_W-1:0];
                    REG_RLE_ENABLE:   rle_enable_reg   <= cfg_data[0];
                endcase
            end
        end
    end

    always_comb begin
        if (image_width_reg == '0) begin
            width_c = DW'(1);
        end else if (int'(image_width_reg) > DIM_MAX_EFF) begin
            width_c = DW'(DIM_MAX_EFF);
        end else begin
            width_c = DW'(image_width_reg);
        end
        if (image_height_reg == '0) begin
            height_c = DW'(1);
        end else if (int'(image_height_reg) > DIM_MAX_EFF) begin
            height_c = DW'(DIM_MAX_EFF);
        end else begin
            height_c = DW'(image_height_reg);
        end
        image_pixels = PIX_W'({{DW{1'b0}}, width_c} * {{DW{1'b0}}, height_c});
    end

    always_comb begin
        if (pixel_bytes_reg == '0) begin
            pb_eff = PB_GRAY;
        end else if (pixel_bytes_reg > PB_BGRA) begin
            pb_eff = PB_BGRA;
        end else begin
            pb_eff = pixel_bytes_reg;
        end
    end

    // Per-byte decode: header, partial pixel, or completed pixel.
    always_comb begin
        logic [15:0]      v1555;
        logic [CNT_W-1:0] left_w, pk_w, rep_w, left_after;
        logic [BYTE_W-1:0] pk_dec;

        expect_header_next = expect_header_reg;
        byte_slot_next     = byte_slot_reg;
        held_bytes_next    = held_bytes_reg;
        run_is_repeat_next = run_is_repeat_reg;
        packet_left_next   = packet_left_reg;
        pixels_left_next   = pixels_left_reg;
        res                = '0;
        res_valid          = 1'b0;
        v1555              = {s_data_byte, held_bytes_reg[7:0]};
        left_w             = CNT_W'(pixels_left_reg);
        pk_w               = CNT_W'(packet_left_reg);
        rep_w              = '0;
        left_after         = '0;
        pk_dec             = packet_left_reg - 8'd1;

        if (expect_header_reg) begin
            packet_left_next   = {1'b0, s_data_byte[6:0]} + 8'd1;
            run_is_repeat_next = s_data_byte[7];
            expect_header_next = 1'b0;
            byte_slot_next     = '0;
            held_bytes_next    = '0;
        end else if (({1'b0, byte_slot_reg} + 3'd1) < pb_eff) begin
            unique case (byte_slot_reg)
                2'd0:    held_bytes_next = held_bytes_reg | {16'd0, s_data_byte};
                2'd1:    held_bytes_next = held_bytes_reg | {8'd0, s_data_byte, 8'd0};
                2'd2:    held_bytes_next = held_bytes_reg | {s_data_byte, 16'd0};
                default: held_bytes_next = held_bytes_reg;
            endcase
            byte_slot_next = byte_slot_reg + 2'd1;
        end else begin
            res_valid = 1'b1;
            unique case (pb_eff)
                PB_GRAY: begin
                    res.red   = s_data_byte;
                    res.alpha = ALPHA_OPAQUE;
                end
                PB_1555: begin
                    res.red   = {v1555[14:10], 3'b000};
                    res.green = {v1555[9:5], 3'b000};
                    res.blue  = {v1555[4:0], 3'b000};
                    res.alpha = v1555[15] ? ALPHA_OPAQUE : '0;
                end
                PB_BGR: begin
                    res.red   = s_data_byte;
                    res.green = held_bytes_reg[15:8];
                    res.blue  = held_bytes_reg[7:0];
                    res.alpha = ALPHA_OPAQUE;
                end
                default: begin
                    res.red   = held_bytes_reg[23:16];
                    res.green = held_bytes_reg[15:8];
                    res.blue  = held_bytes_reg[7:0];
                    res.alpha = s_data_byte;
                end
            endcase
            byte_slot_next  = '0;
            held_bytes_next = '0;

            if (!rle_enable_reg) begin
                rep_w = CNT_W'(1);
            end else if (run_is_repeat_reg) begin
                // A run longer than what is left of the image is clipped.
                if (pk_w > left_w) begin
                    rep_w       = left_w;
                    res.overrun = 1'b1;
                end else begin
                    rep_w = pk_w;
                end
                packet_left_next   = '0;
                expect_header_next = 1'b1;
            end else begin
                rep_w              = CNT_W'(1);
                packet_left_next   = pk_dec;
                expect_header_next = (pk_dec == '0);
            end
            left_after       = left_w - rep_w;
            pixels_left_next = PIX_W'(left_after);
            res.repeat_res   = rep_w[BYTE_W-1:0];
            if (rle_enable_reg && !run_is_repeat_reg && left_after == '0 && pk_dec != '0) begin
                res.overrun = 1'b1;
            end
            if (left_after == '0) begin
                res.last_of_image  = 1'b1;
                pixels_left_next   = image_pixels;
                expect_header_next = rle_enable_reg;
                run_is_repeat_next = 1'b0;
                packet_left_next   = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            expect_header_reg <= RLE_ENABLE_RST;
            byte_slot_reg     <= '0;
            held_bytes_reg    <= '0;
            run_is_repeat_reg <= 1'b0;
            packet_left_reg   <= '0;
        end else if (reload_reg) begin
            expect_header_reg <= rle_enable_reg;
            byte_slot_reg     <= '0;
            held_bytes_reg    <= '0;
            run_is_repeat_reg <= 1'b0;
            packet_left_reg   <= '0;
            pixels_left_reg   <= image_pixels;
        end else if (fire) begin
            expect_header_reg <= expect_header_next;
            byte_slot_reg     <= byte_slot_next;
            held_bytes_reg    <= held_bytes_next;
            run_is_repeat_reg <= run_is_repeat_next;
            packet_left_reg   <= packet_left_next;
            pixels_left_reg   <= pixels_left_next;
        end
    end

    // Output register with a skid stage behind it.
    always_comb begin
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (!out_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end else begin
                out_next       = res;
                out_valid_next = fire && res_valid;
            end
        end else if (fire && res_valid) begin
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        out_reg <= out_next;
        if (out_valid_reg && !m_ready && fire && res_valid) begin
            skid_reg <= res;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_red           = out_reg.red;
    assign m_green         = out_reg.green;
    assign m_blue          = out_reg.blue;
    assign m_alpha         = out_reg.alpha;
    assign m_repeat_res    = out_reg.repeat_res;
    assign m_last_of_image = out_reg.last_of_image;
    assign m_overrun       = out_reg.overrun;

endmodule

[src/tga_rle_chk.sv]
`timescale 1ns / 1ps

module tga_rle_chk (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               cfg_valid,
    input logic                               cfg_ready,
    input logic                               s_ready,
    input logic                               m_valid,
    input logic                               m_ready,
    input logic [tga_rle_pkg::BYTE_W-1:0]     m_red,
    input logic [tga_rle_pkg::BYTE_W-1:0]     m_green,
    input logic [tga_rle_pkg::BYTE_W-1:0]     m_blue,
    input logic [tga_rle_pkg::BYTE_W-1:0]     m_alpha,
    input logic [tga_rle_pkg::BYTE_W-1:0]     m_repeat_res,
    input logic                               m_last_of_image,
    input logic                               m_overrun
);
    import tga_rle_pkg::*;

    // A clipped run always ends the image.
    a_overrun_ends_image: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_overrun |-> m_last_of_image)
        else $error("overrun word without last_of_image");

    a_repeat_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_repeat_res != '0) && (m_repeat_res <= MAX_REPEAT))
        else $error("repeat count out of range");

    // The pixel count reloads in the cycle after a register write.
    a_cfg_reload_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid && cfg_ready |=> !s_ready)
        else $error("input taken during image reload");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_red) && $stable(m_green)
            && $stable(m_blue) && $stable(m_alpha) && $stable(m_repeat_res)
            && $stable(m_last_of_image) && $stable(m_overrun))
        else $error("result word changed while stalled");

endmodule

bind tga_rle_pixel_decoder tga_rle_chk u_tga_rle_chk (.*);
